/* src/uitf_pkg.sv */
// ----------------------------------------------------------------------------
// uitf_pkg
// Shared widths, character codes, state types and control structs of the
// unsigned integer text formatter.
// ----------------------------------------------------------------------------
package uitf_pkg;

    // field widths of the channel payloads
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 2;
    localparam int PREC_W  = 6;
    localparam int WIDTH_W = 7;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 7;

    // default cap on the field length
    localparam int MAX_FIELD_DEF = 64;

    // digit register: twenty four-bit digits covers any 64-bit decimal value
    localparam int DIGIT_SLOTS = 20;
    localparam int DIGIT_W     = 4;
    localparam int TOTAL_W     = $clog2(DIGIT_SLOTS + 1);
    localparam int STORE_W     = DIGIT_SLOTS * DIGIT_W;
    localparam int STEP_W      = $clog2(VALUE_W);

    // radix codes
    localparam logic [RADIX_W-1:0] RADIX_DEC    = 2'd0;
    localparam logic [RADIX_W-1:0] RADIX_HEX_LO = 2'd1;
    localparam logic [RADIX_W-1:0] RADIX_HEX_UP = 2'd2;
    localparam logic [RADIX_W-1:0] RADIX_HEX_AL = 2'd3;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 7'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 7'h78;

    // converter states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_DABBLE,
        CS_NORM,
        CS_DONE
    } t_conv_state;

    // sequencer states
    typedef enum logic [2:0] {
        ES_IDLE,
        ES_CONV,
        ES_PLAN,
        ES_LEAD,
        ES_PREFIX,
        ES_ZERO,
        ES_DIGIT,
        ES_TRAIL
    } t_emit_state;

    // sequencer to converter
    typedef struct packed {
        logic start;
        logic hex;
        logic suppress;
        logic shift;
    } t_conv_ctl;

    // converter to sequencer
    typedef struct packed {
        logic               done;
        logic [TOTAL_W-1:0] total;
        logic [DIGIT_W-1:0] digit;
    } t_conv_sts;

    // one digit to its ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < DIGIT_W'(10)) begin
            digit_char = CH_ZERO + CHAR_W'(d);
        end else begin
            digit_char = base + CHAR_W'(d) - CHAR_W'(10);
        end
    endfunction

endpackage

/* src/uitf_in_if.sv */
// ----------------------------------------------------------------------------
// uitf_in_if
// Input channel: one value with its format fields per transaction.
// ----------------------------------------------------------------------------
interface uitf_in_if;
    import uitf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;
    logic [RADIX_W-1:0]   radix_select;
    logic                 alternate_form;
    logic                 align_left;
    logic                 pad_with_zeros;
    logic                 precision_given;
    logic [PREC_W-1:0]    min_digits;
    logic [WIDTH_W-1:0]   field_width;

    modport source (
        output valid, value, radix_select, alternate_form, align_left,
               pad_with_zeros, precision_given, min_digits, field_width,
        input  ready
    );

    modport sink (
        input  valid, value, radix_select, alternate_form, align_left,
               pad_with_zeros, precision_given, min_digits, field_width,
        output ready
    );
endinterface

/* src/uitf_out_if.sv */
// ----------------------------------------------------------------------------
// uitf_out_if
// Output channel: one character of the formatted field per transaction.
// ----------------------------------------------------------------------------
interface uitf_out_if;
    import uitf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    out_char;
    logic                 last_char;
    logic [COUNT_W-1:0]   char_count;

    modport source (
        output valid, out_char, last_char, char_count,
        input  ready
    );

    modport sink (
        input  valid, out_char, last_char, char_count,
        output ready
    );
endinterface

/* src/uitf_conv.sv */
// ----------------------------------------------------------------------------
// uitf_conv
// Digit converter: shift-and-add-three binary to decimal, one bit per cycle,
// or a direct nibble load for hex, then a leading-zero strip one digit per
// cycle. Digits leave most significant first through a four-bit shift.
// ----------------------------------------------------------------------------
module uitf_conv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  uitf_pkg::t_conv_ctl          i_ctl,
    input  logic [uitf_pkg::VALUE_W-1:0] i_value,
    output uitf_pkg::t_conv_sts          o_sts
);
    import uitf_pkg::*;

    t_conv_state        r_state,    n_state;
    logic [VALUE_W-1:0] r_bin,      n_bin;
    logic [STORE_W-1:0] r_store,    n_store;
    logic [STEP_W-1:0]  r_step,     n_step;
    logic [TOTAL_W-1:0] r_rem,      n_rem;
    logic               r_suppress, n_suppress;
    logic [STORE_W-1:0] w_adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < DIGIT_SLOTS; k++) begin
            w_adj[k*DIGIT_W +: DIGIT_W] =
                (r_store[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
                r_store[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) :
                r_store[k*DIGIT_W +: DIGIT_W];
        end
    end

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_bin      = r_bin;
        n_store    = r_store;
        n_step     = r_step;
        n_rem      = r_rem;
        n_suppress = r_suppress;
        unique case (r_state)
            CS_IDLE, CS_DONE: begin
                if (i_ctl.start) begin
                    n_suppress = i_ctl.suppress;
                    n_rem      = TOTAL_W'(DIGIT_SLOTS);
                    n_step     = '0;
                    if (i_ctl.hex) begin
                        n_store = STORE_W'(i_value);
                        n_state = CS_NORM;
                    end else begin
                        n_bin   = i_value;
                        n_store = '0;
                        n_state = CS_DABBLE;
                    end
                end else if (i_ctl.shift) begin
                    n_store = {r_store[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                end
            end
            CS_DABBLE: begin
                n_store = {w_adj[STORE_W-2:0], r_bin[VALUE_W-1]};
                n_bin   = {r_bin[VALUE_W-2:0], 1'b0};
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_state = CS_NORM;
                end
            end
            CS_NORM: begin
                // strip leading zeros, keep at least one digit
                if (r_store[STORE_W-1 -: DIGIT_W] == '0 && r_rem > TOTAL_W'(1)) begin
                    n_store = {r_store[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_rem   = r_rem - TOTAL_W'(1);
                end else begin
                    n_state = CS_DONE;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_store    <= n_store;
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_suppress <= n_suppress;
    end

    // status to the sequencer
    assign o_sts.done  = (r_state == CS_DONE);
    assign o_sts.total = r_suppress ? '0 : r_rem;
    assign o_sts.digit = r_store[STORE_W-1 -: DIGIT_W];

endmodule

/* src/uitf_emit.sv */
// ----------------------------------------------------------------------------
// uitf_emit
// Field sequencer: takes the input transaction, plans the padding runs and
// sends leading spaces, prefix, zeros, digits and trailing spaces one
// character per cycle into the output register while its slot is free.
// ----------------------------------------------------------------------------
module uitf_emit #(
    parameter int MAX_FIELD = uitf_pkg::MAX_FIELD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    uitf_in_if.sink             i_in,
    uitf_out_if.source          o_out,
    input  uitf_pkg::t_conv_sts i_conv,
    output uitf_pkg::t_conv_ctl o_conv
);
    import uitf_pkg::*;

    localparam int CW = $clog2(MAX_FIELD + 1);
    localparam logic [WIDTH_W-1:0] PREC_CAP  = WIDTH_W'(MAX_FIELD - 2);
    localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(MAX_FIELD);

    t_emit_state       r_state,   n_state;
    logic [CW-1:0]     r_run,     n_run;
    logic [CW-1:0]     r_zero,    n_zero;
    logic [CW-1:0]     r_trail,   n_trail;
    logic [CW-1:0]     r_total,   n_total;
    logic [CW-1:0]     r_emitted, n_emitted;
    logic              r_prefix,  n_prefix;
    logic              r_o_valid, n_o_valid;
    logic [CHAR_W-1:0] r_o_char,  n_o_char;
    logic              r_o_last,  n_o_last;
    logic [CW-1:0]     r_o_count, n_o_count;

    // format of the current transaction
    logic              r_hex, r_upper, r_alt, r_left, r_zpad, r_pg, r_nonzero;
    logic [CW-1:0]     r_prec, r_width;

    logic              w_acc;
    logic [WIDTH_W-1:0] w_prec_cap, w_width_cap;
    logic [CW-1:0]     w_dt, w_shown, w_body, w_pad;
    logic              w_pfx, w_in_run, w_emit, w_last;
    logic [CHAR_W-1:0] w_char;

    assign w_acc      = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ES_IDLE);

    // caps on precision and width
    assign w_prec_cap  = ({1'b0, i_in.min_digits} > PREC_CAP) ? PREC_CAP
                                                               : {1'b0, i_in.min_digits};
    assign w_width_cap = (i_in.field_width > WIDTH_CAP) ? WIDTH_CAP : i_in.field_width;

    // converter control
    assign o_conv.start    = w_acc;
    assign o_conv.hex      = (i_in.radix_select != RADIX_DEC);
    assign o_conv.suppress = i_in.precision_given && (i_in.min_digits == '0) &&
                             (i_in.value == '0);
    assign o_conv.shift    = w_emit && (r_state == ES_DIGIT);

    // field plan: digits shown, body and width padding
    assign w_dt    = CW'(i_conv.total);
    assign w_pfx   = r_hex && r_alt && r_nonzero;
    assign w_shown = (r_pg && r_prec > w_dt) ? r_prec : w_dt;
    assign w_body  = w_shown + (w_pfx ? CW'(2) : CW'(0));
    assign w_pad   = (r_width > w_body) ? r_width - w_body : '0;

    // a character leaves whenever a run is open and the output slot is free
    assign w_in_run = (r_state == ES_LEAD) || (r_state == ES_PREFIX) ||
                      (r_state == ES_ZERO) || (r_state == ES_DIGIT) ||
                      (r_state == ES_TRAIL);
    assign w_emit   = w_in_run && (r_run != '0) && (!r_o_valid || o_out.ready);
    assign w_last   = (CW'(r_emitted + CW'(1)) == r_total);

    // next state, run counters and output register
    always_comb begin
        n_state   = r_state;
        n_run     = r_run;
        n_zero    = r_zero;
        n_trail   = r_trail;
        n_total   = r_total;
        n_emitted = r_emitted;
        n_prefix  = r_prefix;
        n_o_valid = r_o_valid;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        n_o_count = r_o_count;
        w_char    = CH_SPACE;
        unique case (r_state)
            ES_IDLE: begin
                if (w_acc) begin
                    n_state = ES_CONV;
                end
            end
            ES_CONV: begin
                if (i_conv.done) begin
                    n_state = ES_PLAN;
                end
            end
            ES_PLAN: begin
                n_run     = (!r_left && (!r_zpad || r_pg)) ? w_pad : '0;
                n_zero    = ((!r_left && r_zpad && !r_pg) ? w_pad : '0) +
                            (w_shown - w_dt);
                n_trail   = r_left ? w_pad : '0;
                n_total   = w_pad + w_body;
                n_prefix  = w_pfx;
                n_emitted = '0;
                n_state   = ES_LEAD;
            end
            ES_LEAD: begin
                if (r_run == '0) begin
                    n_run   = r_prefix ? CW'(2) : '0;
                    n_state = ES_PREFIX;
                end
            end
            ES_PREFIX: begin
                w_char = (r_run == CW'(2)) ? CH_ZERO : (r_upper ? CH_X_UP : CH_X_LO);
                if (r_run == '0) begin
                    n_run   = r_zero;
                    n_state = ES_ZERO;
                end
            end
            ES_ZERO: begin
                w_char = CH_ZERO;
                if (r_run == '0) begin
                    n_run   = w_dt;
                    n_state = ES_DIGIT;
                end
            end
            ES_DIGIT: begin
                w_char = digit_char(i_conv.digit, r_upper);
                if (r_run == '0) begin
                    n_run   = r_trail;
                    n_state = ES_TRAIL;
                end
            end
            ES_TRAIL: begin
                if (r_run == '0) begin
                    n_state = ES_IDLE;
                end
            end
        endcase

        // output register
        if (w_emit) begin
            n_run     = r_run - CW'(1);
            n_emitted = r_emitted + CW'(1);
            n_o_valid = 1'b1;
            n_o_char  = w_char;
            n_o_last  = w_last;
            n_o_count = w_last ? r_total : '0;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ES_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    // payload and counter registers
    always_ff @(posedge i_clk) begin
        r_run     <= n_run;
        r_zero    <= n_zero;
        r_trail   <= n_trail;
        r_total   <= n_total;
        r_emitted <= n_emitted;
        r_prefix  <= n_prefix;
        r_o_char  <= n_o_char;
        r_o_last  <= n_o_last;
        r_o_count <= n_o_count;
    end

    // capture the format on an input transaction
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_hex     <= (i_in.radix_select != RADIX_DEC);
            r_upper   <= (i_in.radix_select inside {RADIX_HEX_UP, RADIX_HEX_AL});
            r_alt     <= i_in.alternate_form;
            r_left    <= i_in.align_left;
            r_zpad    <= i_in.pad_with_zeros;
            r_pg      <= i_in.precision_given;
            r_nonzero <= (i_in.value != '0);
            r_prec    <= CW'(w_prec_cap);
            r_width   <= CW'(w_width_cap);
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.out_char   = r_o_char;
    assign o_out.last_char  = r_o_last;
    assign o_out.char_count = COUNT_W'(r_o_count);

endmodule

/* src/unsigned_integer_text_formatter.sv */
// ----------------------------------------------------------------------------
// unsigned_integer_text_formatter
// printf-style %u / %x / %X formatter: one 64-bit value in, its ASCII field
// out one character per transaction.
// ----------------------------------------------------------------------------
// Usage
//   i_in  : one value with radix, alternate form, left alignment, zero flag,
//           precision and field width per transaction; ready is high only
//           while no value is being worked on.
//   o_out : one character per transaction, last_char on the final one,
//           char_count carrying the field length on that final character.
//   A value with zero precision, value zero and width zero gives no output.
// Operation
//   Decimal: shift-and-add-three over every bit of the value, then the
//   leading zeros are stripped one by one. Hex: the nibbles load at once,
//   then the same strip, which always drops at least four zeros. The field
//   is then planned and sent one character per cycle while the output slot
//   is free, in five runs (spaces, prefix, zeros, digits, spaces).
// Reset and stalls
//   Synchronous reset empties the output register and returns to idle.
//   While o_out.ready is low the character holds in the output register and
//   the sequencer waits; ready returns after the last character of the field
//   has entered the output register and the sequencer has left its last run.
// ----------------------------------------------------------------------------
module unsigned_integer_text_formatter #(
    parameter int MAX_FIELD = uitf_pkg::MAX_FIELD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uitf_in_if.sink    i_in,
    uitf_out_if.source o_out
);
    import uitf_pkg::*;

    t_conv_ctl w_ctl;
    t_conv_sts w_sts;

    // digit converter
    uitf_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_value (i_in.value),
        .o_sts   (w_sts)
    );

    // field sequencer and output register
    uitf_emit #(
        .MAX_FIELD (MAX_FIELD)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_conv  (w_sts),
        .o_conv  (w_ctl)
    );

    // digits only leave a finished conversion
    a_shift_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift |-> w_sts.done)
        else $error("digit shift before conversion finished");

    // one value at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a value is in progress");

    // field length only on the final character, and within the cap
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_char) |->
        (o_out.char_count != '0 && o_out.char_count <= COUNT_W'(MAX_FIELD)))
        else $error("bad field length on final character");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_char) |-> (o_out.char_count == '0))
        else $error("field length on a non-final character");

endmodule
